// ===== rtl/lphs_pkg.sv =====
`timescale 1ns / 1ps

package lphs_pkg;

   // default build parameters
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_KEY_BITS    = 32;

   // fixed field widths on the ports
   localparam int KEY_FIELD_W  = 32;
   localparam int SLOT_FIELD_W = 10;
   localparam int CFG_SIZE_W   = 11;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int RSP_DATA_W   = 16;

   // register indexes on the csr port
   localparam logic CSR_TABLE_SIZE = 1'b0;

   // request kinds
   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_type_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIVIDE,
      ST_HOME,
      ST_READ,
      ST_CHECK,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/lphs_ram.sv =====
`timescale 1ns / 1ps

module lphs_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/linear_probe_hash_set.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  tuser: req_type; tdata: key
// rsp_      out        rsp_tvalid/rsp_tready  tdata: found, slot, status
// csr_      in         apb write/read         table_size at byte address 0
//
// lookup/insert: the shared restoring divider (ST_DIVIDE) finds the home
// slot, ST_HOME folds the remainder, then each probe takes ST_READ and
// ST_CHECK through the key memory read port, then ST_DONE hands off the
// result, waiting while an earlier result still waits for rsp_tready.
// clear: every memory row swept to empty, one row written per cycle.
// after reset the same sweep runs with req_tready low.
// a new request is taken while a result still waits in the output register.

module linear_probe_hash_set #(
   parameter int TABLE_DEPTH = lphs_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = lphs_pkg::DEF_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lphs_pkg::KEY_FIELD_W-1:0]   req_tdata,   // [31:0] key
   input  logic [1:0]                         req_tuser,   // [1:0] req_type
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lphs_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [0] found, [10:1] slot,
                                                           // [11] status, [15:12] zero
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lphs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lphs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lphs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   import lphs_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int SIZE_W = (IDX_W + 1 > CFG_SIZE_W) ? IDX_W + 1 : CFG_SIZE_W;
   localparam int CNT_W  = $clog2(KEY_BITS);
   localparam int ENT_W  = KEY_BITS + 1;

   state_type             state_ff, state_in;
   req_type_type          kind_ff, kind_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic                  neg_ff, neg_in;
   logic [KEY_BITS-1:0]   dvd_ff, dvd_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [SIZE_W-1:0]     steps_ff, steps_in;
   logic                  res_found_ff, res_found_in;
   logic [SLOT_FIELD_W-1:0] res_slot_ff, res_slot_in;
   logic                  res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]     table_size_ff, table_size_in;

   logic [KEY_BITS-1:0]   key_ext;
   logic [SIZE_W-1:0]     eff_size;
   logic [SIZE_W:0]       div_trial;
   logic [SIZE_W:0]       pos_next;
   logic                  csr_write;
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [ENT_W-1:0]      ram_wr_data;
   logic                  ram_rd_en;
   logic [ENT_W-1:0]      ram_rd_data;
   logic                  ent_valid;
   logic [KEY_BITS-1:0]   ent_key;

   // key memory: valid bit on top of the stored key
   lphs_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   assign ent_valid = ram_rd_data[KEY_BITS];
   assign ent_key   = ram_rd_data[KEY_BITS-1:0];

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_TABLE_SIZE) ? CSR_DATA_W'(table_size_ff)
                                                        : '0;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_write && (csr_paddr[2] == CSR_TABLE_SIZE)) begin
         table_size_in = SIZE_W'(csr_pwdata[CFG_SIZE_W-1:0]);
      end
   end

   // effective size: zero acts as one, saturate at the table depth
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (table_size_ff > SIZE_W'(TABLE_DEPTH)) begin
         eff_size = SIZE_W'(TABLE_DEPTH);
      end else begin
         eff_size = table_size_ff;
      end
   end

   // key sign-extended or cut to the stored key width
   assign key_ext = KEY_BITS'($signed(req_tdata));

   // shared divider step and probe advance
   assign div_trial = {rem_ff, dvd_ff[KEY_BITS-1]};
   assign pos_next  = (SIZE_W + 1)'(pos_ff) + (SIZE_W + 1)'(1);

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      neg_in        = neg_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      size_in       = size_ff;
      pos_in        = pos_ff;
      steps_in      = steps_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;

      // output register drains on a transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // sweep every row to empty
            ram_wr_en = 1'b1;
            if (pos_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in       = req_type_type'(req_tuser);
               key_in        = key_ext;
               neg_in        = key_ext[KEY_BITS-1];
               dvd_in        = key_ext[KEY_BITS-1] ? (~key_ext + KEY_BITS'(1)) : key_ext;
               rem_in        = '0;
               bit_cnt_in    = '0;
               size_in       = eff_size;
               pos_in        = '0;
               res_found_in  = 1'b0;
               res_slot_in   = '0;
               res_status_in = 1'b0;
               unique case (req_type_type'(req_tuser))
                  REQ_LOOKUP, REQ_INSERT: state_in = ST_DIVIDE;
                  REQ_CLEAR:              state_in = ST_CLEAR;
                  default:                state_in = ST_DONE;
               endcase
            end
         end
         ST_DIVIDE: begin
            // restoring division, one quotient bit a cycle
            dvd_in = dvd_ff << 1;
            if (div_trial >= {1'b0, size_ff}) begin
               rem_in = SIZE_W'(div_trial - {1'b0, size_ff});
            end else begin
               rem_in = SIZE_W'(div_trial);
            end
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == CNT_W'(KEY_BITS - 1)) begin
               state_in = ST_HOME;
            end
         end
         ST_HOME: begin
            // non-negative remainder for negative keys
            if (neg_ff && (rem_ff != '0)) begin
               pos_in = IDX_W'(size_ff - rem_ff);
            end else begin
               pos_in = IDX_W'(rem_ff);
            end
            steps_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!ent_valid) begin
               if (kind_ff == REQ_INSERT) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, key_ff};
                  res_slot_in = SLOT_FIELD_W'(pos_ff);
               end
               state_in = ST_DONE;
            end else if (ent_key == key_ff) begin
               res_found_in = 1'b1;
               res_slot_in  = SLOT_FIELD_W'(pos_ff);
               state_in     = ST_DONE;
            end else if (steps_ff + SIZE_W'(1) == size_ff) begin
               // full lap without a match or a hole
               res_status_in = (kind_ff == REQ_INSERT);
               state_in      = ST_DONE;
            end else begin
               steps_in = steps_ff + SIZE_W'(1);
               pos_in   = (pos_next >= {1'b0, size_ff}) ? '0 : IDX_W'(pos_next);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= SIZE_W'(TABLE_DEPTH);
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_size_ff <= table_size_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      neg_ff        <= neg_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      size_ff       <= size_in;
      steps_ff      <= steps_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_slot_ff, rsp_found_ff};

endmodule
